FILE: design/joint_motion_command_framer_assert.svh
// ----------------------------------------------------------------------------
// Joint motion command framer assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JOINT_MOTION_COMMAND_FRAMER_ASSERT_SVH
`define JOINT_MOTION_COMMAND_FRAMER_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define JMCF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define JMCF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/jmcf_pkg.sv
// ----------------------------------------------------------------------------
// Joint motion command framer package
// Shared types, register map, frame codes and the frame byte layout.
// ----------------------------------------------------------------------------
package jmcf_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int QUEUE_DEPTH = 4;
    localparam int ADDR_W      = 5;

    localparam logic [7:0] HDR_BYTE   = 8'hAD;
    localparam logic [7:0] END_BYTE   = 8'hCC;
    localparam logic [7:0] OP_SET_VEL = 8'h9E;
    localparam logic [7:0] OP_SET_POS = 8'hA0;
    localparam logic [7:0] OP_MOVE    = 8'h96;
    localparam logic [7:0] OP_STOP    = 8'h97;
    localparam logic [7:0] DATA_LEN   = 8'h04;
    localparam logic [7:0] NO_LEN     = 8'h00;

    localparam logic signed [31:0] MIN_STEP = 32'sd66;

    localparam logic [IDX_W-1:0] BYTE_HDR  = IDX_W'(0);
    localparam logic [IDX_W-1:0] BYTE_ADDR = IDX_W'(1);
    localparam logic [IDX_W-1:0] BYTE_OP   = IDX_W'(2);
    localparam logic [IDX_W-1:0] BYTE_LEN  = IDX_W'(3);
    localparam logic [IDX_W-1:0] BYTE_D0   = IDX_W'(4);
    localparam logic [IDX_W-1:0] BYTE_D1   = IDX_W'(5);
    localparam logic [IDX_W-1:0] BYTE_D2   = IDX_W'(6);
    localparam logic [IDX_W-1:0] BYTE_D3   = IDX_W'(7);
    localparam logic [IDX_W-1:0] BYTE_END  = IDX_W'(FRAME_BYTES - 1);

    localparam logic        RST_MOVE_MODE   = 1'b0;
    localparam logic [7:0]  RST_MOTOR_ADDR  = 8'd1;
    localparam logic [15:0] RST_GAIN_Q8     = 16'd256;
    localparam logic [30:0] RST_STOP_BAND   = 31'd655;
    localparam logic [30:0] RST_SPEED_LIMIT = 31'd65536;
    localparam logic [31:0] RST_LOWER_LIMIT = 32'h8000_0000;
    localparam logic [31:0] RST_UPPER_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] RST_PULSES      = 32'd10430379;

    typedef enum logic [2:0] {
        REG_MOVE_MODE   = 3'd0,
        REG_MOTOR_ADDR  = 3'd1,
        REG_GAIN_Q8     = 3'd2,
        REG_STOP_BAND   = 3'd3,
        REG_SPEED_LIMIT = 3'd4,
        REG_LOWER_LIMIT = 3'd5,
        REG_UPPER_LIMIT = 3'd6,
        REG_PULSES      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic               move_mode;
        logic [7:0]         motor_addr;
        logic [15:0]        gain_q8;
        logic [30:0]        stop_band;
        logic [30:0]        speed_limit;
        logic signed [31:0] lower_limit;
        logic signed [31:0] upper_limit;
        logic [31:0]        pulses_per_radian;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  op;
        logic [31:0] data;
        logic        last;
    } frame_t;

    function automatic logic [7:0] frame_byte_at(logic [IDX_W-1:0] idx, logic [7:0] dev,
                                                 frame_t f);
        logic [7:0] len;
        logic [7:0] b;
        len = ((f.op == OP_SET_VEL) || (f.op == OP_SET_POS)) ? DATA_LEN : NO_LEN;
        case (idx)
            BYTE_HDR:  b = HDR_BYTE;
            BYTE_ADDR: b = dev;
            BYTE_OP:   b = f.op;
            BYTE_LEN:  b = len;
            BYTE_D0:   b = f.data[7:0];
            BYTE_D1:   b = f.data[15:8];
            BYTE_D2:   b = f.data[23:16];
            BYTE_D3:   b = f.data[31:24];
            BYTE_END:  b = END_BYTE;
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: design/jmcf_if.sv
// ----------------------------------------------------------------------------
// Joint motion command framer channels
// Command input channel and frame byte output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jmcf_cmd_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] goal_pos;
    logic               pos_given;
    logic signed [31:0] goal_vel;
    logic               vel_given;
    logic signed [31:0] measured_pos;

    modport source (
        output valid, action, goal_pos, pos_given, goal_vel, vel_given, measured_pos,
        input  ready
    );
    modport sink (
        input  valid, action, goal_pos, pos_given, goal_vel, vel_given, measured_pos,
        output ready
    );
endinterface

interface jmcf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       last;

    modport source (
        output valid, frame_byte, frame_end, last,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, frame_end, last,
        output ready
    );
endinterface

FILE: design/jmcf_front.sv
// ----------------------------------------------------------------------------
// Joint motion command framer front end
// Accepts commands, keeps the stored target and computes the frames to send.
// ----------------------------------------------------------------------------
module jmcf_front (
    input  logic             clk,
    input  logic             rst_n,
    jmcf_cmd_if.sink         cmd,
    input  jmcf_pkg::cfg_t   cfg,
    input  logic             q_full,
    output logic             q_push,
    output jmcf_pkg::frame_t q_frame
);
    import jmcf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_JCHK   = 7'b0000010,
        S_JVEL   = 7'b0000100,
        S_PCLAMP = 7'b0001000,
        S_PMUL   = 7'b0010000,
        S_PRND   = 7'b0100000,
        S_MOVE   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic signed [31:0] stored_target_reg, stored_target_next;
    logic               stored_valid_reg, stored_valid_next;

    logic signed [31:0] tp_reg, tp_next;
    logic signed [31:0] tv_reg, tv_next;
    logic               vel_given_reg, vel_given_next;
    logic signed [32:0] e_reg, e_next;
    logic signed [49:0] eg_reg, eg_next;
    logic [31:0]        mul_mag_reg, mul_mag_next;
    logic               mul_neg_reg, mul_neg_next;
    logic               conv_pos_reg, conv_pos_next;
    logic signed [31:0] pos_reg, pos_next;
    logic [63:0]        prod_reg, prod_next;

    logic               accept;
    logic signed [32:0] d_st, d_abs, e_in, e_abs;
    logic signed [31:0] tv_eff;
    logic signed [50:0] v_sum, v_lim, v_clamp, v_mag;
    logic [39:0]        r_sum;
    logic signed [31:0] lim_s, v_sel, v_lo, p_lo, p_hi;
    logic signed [32:0] pos_neg;
    logic [64:0]        q_sum;
    logic [32:0]        q_raw, q_neg;
    logic [31:0]        pulses, pulse_data;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        d_st    = 33'(cmd.goal_pos) - 33'(stored_target_reg);
        d_abs   = (d_st < 0) ? -d_st : d_st;
        e_in    = 33'(cmd.goal_pos) - 33'(cmd.measured_pos);
        e_abs   = (e_reg < 0) ? -e_reg : e_reg;

        tv_eff  = vel_given_reg ? tv_reg : 32'sd0;
        v_sum   = (51'(tv_eff) <<< 8) + 51'(eg_reg);
        v_lim   = $signed({12'b0, cfg.speed_limit, 8'b0});
        if (v_sum > v_lim)
        begin
            v_clamp = v_lim;
        end
        else if (v_sum < -v_lim)
        begin
            v_clamp = -v_lim;
        end
        else
        begin
            v_clamp = v_sum;
        end
        v_mag   = (v_clamp < 0) ? -v_clamp : v_clamp;
        r_sum   = v_mag[39:0] + 40'd128;

        lim_s   = $signed({1'b0, cfg.speed_limit});
        v_sel   = (vel_given_reg && (tv_reg > 0)) ? tv_reg : lim_s;
        v_lo    = (v_sel < MIN_STEP) ? MIN_STEP : v_sel;
        p_lo    = (tp_reg < cfg.lower_limit) ? cfg.lower_limit : tp_reg;
        p_hi    = (p_lo > cfg.upper_limit) ? cfg.upper_limit : p_lo;

        pos_neg = -33'(pos_reg);

        q_sum   = {1'b0, prod_reg} + 65'h0_8000_0000;
        q_raw   = q_sum[64:32];
        q_neg   = (q_raw > 33'h0_8000_0000) ? 33'h0_8000_0000 : q_raw;
        if (mul_neg_reg)
        begin
            pulses = 32'd0 - q_neg[31:0];
        end
        else
        begin
            pulses = (q_raw > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_raw[31:0];
        end
        pulse_data = (cfg.move_mode && !conv_pos_reg && (pulses == 32'd0)) ? 32'd1 : pulses;
    end

    always_comb
    begin
        state_next         = state_reg;
        stored_target_next = stored_target_reg;
        stored_valid_next  = stored_valid_reg;
        tp_next            = tp_reg;
        tv_next            = tv_reg;
        vel_given_next     = vel_given_reg;
        e_next             = e_reg;
        eg_next            = eg_reg;
        mul_mag_next       = mul_mag_reg;
        mul_neg_next       = mul_neg_reg;
        conv_pos_next      = conv_pos_reg;
        pos_next           = pos_reg;
        prod_next          = prod_reg;
        q_push             = 1'b0;
        q_frame            = '{op: OP_MOVE, data: 32'd0, last: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tp_next        = cmd.goal_pos;
                    tv_next        = cmd.goal_vel;
                    vel_given_next = cmd.vel_given;
                    e_next         = e_in;
                    if (cmd.action)
                    begin
                        stored_target_next = cmd.measured_pos;
                        stored_valid_next  = 1'b1;
                    end
                    else if (cmd.pos_given)
                    begin
                        if (!cfg.move_mode)
                        begin
                            if (!(stored_valid_reg && (cmd.goal_pos == stored_target_reg)))
                            begin
                                state_next = S_JCHK;
                            end
                        end
                        else if (!(stored_valid_reg && (d_abs < 33'sd66)))
                        begin
                            stored_target_next = cmd.goal_pos;
                            stored_valid_next  = 1'b1;
                            state_next         = S_PCLAMP;
                        end
                    end
                end
            end
            S_JCHK:
            begin
                if (e_abs < $signed({2'b0, cfg.stop_band}))
                begin
                    if (!q_full)
                    begin
                        q_push             = 1'b1;
                        q_frame            = '{op: OP_STOP, data: 32'd0, last: 1'b1};
                        stored_target_next = tp_reg;
                        stored_valid_next  = 1'b1;
                        state_next         = S_IDLE;
                    end
                end
                else
                begin
                    eg_next    = 50'(e_reg) * 50'($signed({1'b0, cfg.gain_q8}));
                    state_next = S_JVEL;
                end
            end
            S_JVEL:
            begin
                mul_mag_next  = r_sum[39:8];
                mul_neg_next  = (v_clamp < 0);
                conv_pos_next = 1'b0;
                state_next    = S_PMUL;
            end
            S_PCLAMP:
            begin
                mul_mag_next  = (v_lo > lim_s) ? lim_s : v_lo;
                mul_neg_next  = 1'b0;
                conv_pos_next = 1'b0;
                pos_next      = p_hi;
                state_next    = S_PMUL;
            end
            S_PMUL:
            begin
                prod_next  = 64'(mul_mag_reg) * 64'(cfg.pulses_per_radian);
                state_next = S_PRND;
            end
            S_PRND:
            begin
                if (!q_full)
                begin
                    q_push  = 1'b1;
                    q_frame = '{op: (conv_pos_reg ? OP_SET_POS : OP_SET_VEL),
                                data: pulse_data, last: 1'b0};
                    if (cfg.move_mode && !conv_pos_reg)
                    begin
                        mul_neg_next  = (pos_reg < 0);
                        mul_mag_next  = (pos_reg < 0) ? pos_neg[31:0] : pos_reg;
                        conv_pos_next = 1'b1;
                        state_next    = S_PMUL;
                    end
                    else
                    begin
                        state_next = S_MOVE;
                    end
                end
            end
            S_MOVE:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    q_frame    = '{op: OP_MOVE, data: 32'd0, last: 1'b1};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            stored_target_reg <= '0;
            stored_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            stored_target_reg <= stored_target_next;
            stored_valid_reg  <= stored_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tp_reg        <= tp_next;
        tv_reg        <= tv_next;
        vel_given_reg <= vel_given_next;
        e_reg         <= e_next;
        eg_reg        <= eg_next;
        mul_mag_reg   <= mul_mag_next;
        mul_neg_reg   <= mul_neg_next;
        conv_pos_reg  <= conv_pos_next;
        pos_reg       <= pos_next;
        prod_reg      <= prod_next;
    end

endmodule

FILE: design/jmcf_queue.sv
// ----------------------------------------------------------------------------
// Joint motion command framer frame queue
// Short first-in first-out queue of frame descriptors between the two ends.
// ----------------------------------------------------------------------------
`include "joint_motion_command_framer_assert.svh"

module jmcf_queue #(
    parameter int DEPTH = jmcf_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jmcf_pkg::frame_t push_frame,
    input  logic             pop,
    output jmcf_pkg::frame_t head,
    output logic             full,
    output logic             empty
);
    import jmcf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    `JMCF_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count above depth")
    `JMCF_ASSERT_IMPLIES(a_no_overflow, push, !full, "push into a full frame queue")

endmodule

FILE: design/jmcf_back.sv
// ----------------------------------------------------------------------------
// Joint motion command framer back end
// Serializes queued frames into bytes behind a registered output stage.
// ----------------------------------------------------------------------------
`include "joint_motion_command_framer_assert.svh"

module jmcf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       motor_addr,
    input  jmcf_pkg::frame_t head,
    input  logic             q_empty,
    output logic             pop,
    jmcf_frame_if.source     frame
);
    import jmcf_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg;
    logic             end_reg;
    logic             last_reg;
    logic             load;
    logic             take;
    logic             at_end;

    assign load   = !out_valid_reg || frame.ready;
    assign take   = load && !q_empty;
    assign at_end = (idx_reg == BYTE_END);
    assign pop    = take && at_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = !q_empty;
        end
        if (take)
        begin
            idx_next = at_end ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= frame_byte_at(idx_reg, motor_addr, head);
            end_reg  <= at_end;
            last_reg <= at_end && head.last;
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = byte_reg;
    assign frame.frame_end  = end_reg;
    assign frame.last       = last_reg;

    `JMCF_ASSERT_IMPLIES(a_frame_held, idx_reg != '0, !q_empty, "frame left queue mid-send")
    `JMCF_ASSERT_IMPLIES(a_last_ends, frame.valid && frame.last, frame.frame_end, "last off frame end")
    `JMCF_ASSERT_IMPLIES(a_end_byte, frame.valid && frame.frame_end, frame.frame_byte == END_BYTE, "bad footer byte")

endmodule

FILE: design/joint_motion_command_framer.sv
// ----------------------------------------------------------------------------
// Joint motion command framer
// Turns joint commands into 16-byte stepper motor command frames.
// ----------------------------------------------------------------------------
// The front end takes one command at a time and is not ready again until it has
// queued the frames of that command, waiting while the queue is full; jog velocity
// and point-to-point commands share its single 32 by 32 bit pulse multiplier.
// Frames wait in a queue of QUEUE_DEPTH entries and leave as one byte per transfer,
// up to three frames per command. The user must write registers over the APB port
// only while idle; the block itself does not enforce this.
module joint_motion_command_framer #(
    parameter int QUEUE_DEPTH = jmcf_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    jmcf_cmd_if.sink                    cmd,
    jmcf_frame_if.source                frame,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jmcf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import jmcf_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;
    frame_t   push_frame;
    frame_t   head;
    logic     q_push, q_pop, q_full, q_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_mode         <= RST_MOVE_MODE;
            cfg_reg.motor_addr        <= RST_MOTOR_ADDR;
            cfg_reg.gain_q8           <= RST_GAIN_Q8;
            cfg_reg.stop_band         <= RST_STOP_BAND;
            cfg_reg.speed_limit       <= RST_SPEED_LIMIT;
            cfg_reg.lower_limit       <= RST_LOWER_LIMIT;
            cfg_reg.upper_limit       <= RST_UPPER_LIMIT;
            cfg_reg.pulses_per_radian <= RST_PULSES;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_MOVE_MODE:   cfg_reg.move_mode         <= pwdata[0];
                REG_MOTOR_ADDR:  cfg_reg.motor_addr        <= pwdata[7:0];
                REG_GAIN_Q8:     cfg_reg.gain_q8           <= pwdata[15:0];
                REG_STOP_BAND:   cfg_reg.stop_band         <= pwdata[30:0];
                REG_SPEED_LIMIT: cfg_reg.speed_limit       <= pwdata[30:0];
                REG_LOWER_LIMIT: cfg_reg.lower_limit       <= pwdata;
                REG_UPPER_LIMIT: cfg_reg.upper_limit       <= pwdata;
                REG_PULSES:      cfg_reg.pulses_per_radian <= pwdata;
                default:         cfg_reg.move_mode         <= cfg_reg.move_mode;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MOVE_MODE:   prdata = {31'd0, cfg_reg.move_mode};
            REG_MOTOR_ADDR:  prdata = {24'd0, cfg_reg.motor_addr};
            REG_GAIN_Q8:     prdata = {16'd0, cfg_reg.gain_q8};
            REG_STOP_BAND:   prdata = {1'b0, cfg_reg.stop_band};
            REG_SPEED_LIMIT: prdata = {1'b0, cfg_reg.speed_limit};
            REG_LOWER_LIMIT: prdata = cfg_reg.lower_limit;
            REG_UPPER_LIMIT: prdata = cfg_reg.upper_limit;
            REG_PULSES:      prdata = cfg_reg.pulses_per_radian;
            default:         prdata = 32'd0;
        endcase
    end

    jmcf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_frame (push_frame)
    );

    jmcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_frame (push_frame),
        .pop        (q_pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    jmcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .motor_addr (cfg_reg.motor_addr),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (q_pop),
        .frame      (frame)
    );

endmodule
